[hdl/slte_pkg.sv]
package slte_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
  } slte_in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] position;
    logic [4:0] entry_count;
    logic [1:0] status;
  } slte_out_t;

  typedef struct packed {
    logic do_append;
    logic do_insert;
    logic do_remove;
    logic do_sort;
    logic sort_phase;
  } slte_ctrl_t;

  typedef struct packed {
    logic ge_before;
    logic eq_before;
  } slte_chain_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SORT = 2'b10
  } slte_state_t;

endpackage

[hdl/sorted_list_table_engine.sv]
// Fixed-capacity list of signed keys held in a row of cells, one key per cell. Append,
// ordered insert, remove and search need no busy state: every cell compares its key
// at once and a priority chain along the row picks the lowest match or insert point,
// and the result word is loaded the cycle the item is taken. Sort runs odd-even
// transposition over the row and then posts the result, with the input held off
// meanwhile. A result word waiting in the output register holds off the next item,
// sort included, until it is taken, which may be in that same cycle.
module sorted_list_table_engine #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slte_pkg::slte_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slte_pkg::slte_out_t out_data
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KW_EXT = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;

  slte_pkg::slte_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      pass_r, pass_nxt;
  logic                  out_valid_r, out_valid_nxt;
  slte_pkg::slte_out_t   out_data_r, out_data_nxt;

  logic signed [KW_EXT-1:0]    key_ext;
  logic signed [KEY_WIDTH-1:0] key_k;
  slte_pkg::slte_ctrl_t        ctrl;
  logic signed [KEY_WIDTH-1:0] entry_w [CAPACITY];
  slte_pkg::slte_chain_t       chain [CAPACITY+1];
  logic [CAPACITY-1:0]         ins_first;
  logic [CAPACITY-1:0]         eq_first;
  logic [IDX_W-1:0]            ins_pos;
  logic [IDX_W-1:0]            eq_pos;
  logic                        accept;
  logic                        out_free;
  logic                        full;

  assign key_ext  = KW_EXT'(in_data.key);
  assign key_k    = key_ext[KEY_WIDTH-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == slte_pkg::FSM_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign chain[0] = '0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] left_e;
      logic signed [KEY_WIDTH-1:0] right_e;
      if (g == 0) begin : g_first
        assign left_e = entry_w[g];
      end else begin : g_mid_l
        assign left_e = entry_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_e = entry_w[g];
      end else begin : g_mid_r
        assign right_e = entry_w[g+1];
      end
      slte_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .INDEX     (g)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .key         (key_k),
        .count       (count_r),
        .left_entry  (left_e),
        .right_entry (right_e),
        .chain_i     (chain[g]),
        .chain_o     (chain[g+1]),
        .ins_first   (ins_first[g]),
        .eq_first    (eq_first[g]),
        .entry       (entry_w[g])
      );
    end
  endgenerate

  always_comb begin
    ins_pos = '0;
    eq_pos  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_first[i]) ins_pos = ins_pos | IDX_W'(i);
      if (eq_first[i])  eq_pos  = eq_pos | IDX_W'(i);
    end
  end

  always_comb begin
    logic [IDX_W-1:0] pos;
    logic             fnd;
    logic [1:0]       st;
    state_nxt     = state_r;
    count_nxt     = count_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    pos           = '0;
    fnd           = 1'b0;
    st            = slte_pkg::ST_OK;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      slte_pkg::FSM_IDLE: begin
        if (accept) begin
          case (in_data.op)
            slte_pkg::OP_APPEND, slte_pkg::OP_INSERT: begin
              if (full) begin
                st = slte_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                if (in_data.op == slte_pkg::OP_APPEND) begin
                  ctrl.do_append = 1'b1;
                  pos = count_r[IDX_W-1:0];
                end else begin
                  ctrl.do_insert = 1'b1;
                  pos = chain[CAPACITY].ge_before ? ins_pos : count_r[IDX_W-1:0];
                end
              end
            end
            slte_pkg::OP_REMOVE, slte_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                st = slte_pkg::ST_EMPTY;
              end else if (chain[CAPACITY].eq_before) begin
                fnd = 1'b1;
                pos = eq_pos;
                if (in_data.op == slte_pkg::OP_REMOVE) begin
                  ctrl.do_remove = 1'b1;
                  count_nxt = count_r - 1'b1;
                end
              end else begin
                st = slte_pkg::ST_ABSENT;
              end
            end
            default: ;
          endcase
          if (in_data.op == slte_pkg::OP_SORT) begin
            state_nxt = slte_pkg::FSM_SORT;
            pass_nxt  = '0;
          end else begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.found       = fnd;
            out_data_nxt.position    = 4'(pos);
            out_data_nxt.entry_count = 5'(count_nxt);
            out_data_nxt.status      = st;
          end
        end
      end
      slte_pkg::FSM_SORT: begin
        if (pass_r != CNT_W'(CAPACITY)) begin
          ctrl.do_sort    = 1'b1;
          ctrl.sort_phase = pass_r[0];
          pass_nxt        = pass_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = 1'b0;
          out_data_nxt.position    = '0;
          out_data_nxt.entry_count = 5'(count_r);
          out_data_nxt.status      = slte_pkg::ST_OK;
          state_nxt                = slte_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = slte_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slte_pkg::FSM_IDLE;
      count_r     <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_sort_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.op == slte_pkg::OP_SORT) |=> !in_ready)
    else $error("input taken during sort");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.op == slte_pkg::OP_APPEND) && !full
    |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow the list");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == slte_pkg::ST_FULL)
    |-> out_data_r.entry_count == 5'(CAPACITY))
    else $error("full status with list not full");

endmodule

[hdl/slte_cell.sv]
module slte_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                        clk,
  input  slte_pkg::slte_ctrl_t        ctrl,
  input  logic signed [KEY_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]            count,
  input  logic signed [KEY_WIDTH-1:0] left_entry,
  input  logic signed [KEY_WIDTH-1:0] right_entry,
  input  slte_pkg::slte_chain_t       chain_i,
  output slte_pkg::slte_chain_t       chain_o,
  output logic                        ins_first,
  output logic                        eq_first,
  output logic signed [KEY_WIDTH-1:0] entry
);

  localparam logic LEFT_PARITY = 1'((INDEX % 2));
  localparam logic HAS_LEFT    = (INDEX > 0);

  logic signed [KEY_WIDTH-1:0] entry_r;
  logic signed [KEY_WIDTH-1:0] entry_nxt;
  logic                        valid;
  logic                        valid_nb;
  logic                        at_end;
  logic                        ge;
  logic                        eq;
  logic                        ins_here;

  assign valid    = CNT_W'(INDEX) < count;
  assign valid_nb = CNT_W'(INDEX + 1) < count;
  assign at_end   = CNT_W'(INDEX) == count;
  assign ge       = valid && (entry_r >= key);
  assign eq       = valid && (entry_r == key);
  assign ins_here = !chain_i.ge_before && (ge || at_end);
  assign ins_first = !chain_i.ge_before && ge;
  assign eq_first  = !chain_i.eq_before && eq;
  assign chain_o.ge_before = chain_i.ge_before | ge;
  assign chain_o.eq_before = chain_i.eq_before | eq;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.do_append) begin
      if (at_end) entry_nxt = key;
    end else if (ctrl.do_insert) begin
      if (ins_here) entry_nxt = key;
      else if (chain_i.ge_before) entry_nxt = left_entry;
    end else if (ctrl.do_remove) begin
      if (chain_i.eq_before || eq) entry_nxt = right_entry;
    end else if (ctrl.do_sort) begin
      if (ctrl.sort_phase == LEFT_PARITY) begin
        if (valid_nb && (entry_r > right_entry)) entry_nxt = right_entry;
      end else begin
        if (HAS_LEFT && valid && (left_entry > entry_r)) entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[tb/sorted_list_table_engine_checker.sv]
module sorted_list_table_engine_checker
  import slte_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  slte_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  slte_out_t out_data,
  output int        mismatches,
  output int        replies_due,
  output int        replies_seen,
  output int        full_rejects,
  output int        empty_replies,
  output int        keys_matched
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] list_keys [CAPACITY];
  int                 list_len;
  slte_out_t          list_replies_q [$];

  function automatic slte_out_t apply_list_op(input slte_in_t w);
    slte_out_t          r;
    logic signed [31:0] k;
    logic signed [31:0] tmp;
    int                 slot;
    int                 i;
    int                 j;
    r = '0;
    k = w.key;
    slot = -1;
    case (w.op)
      OP_APPEND, OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot = list_len;
          if (w.op == OP_INSERT) begin
            for (i = list_len - 1; i >= 0; i--) begin
              if (list_keys[i] >= k) slot = i;
            end
            for (i = list_len; i > slot; i--) list_keys[i] = list_keys[i - 1];
          end
          list_keys[slot] = k;
          list_len++;
          r.position = slot[3:0];
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = list_len - 1; i >= 0; i--) begin
            if (list_keys[i] == k) slot = i;
          end
          if (slot < 0) begin
            r.status = ST_ABSENT;
          end else begin
            r.found    = 1'b1;
            r.position = slot[3:0];
            if (w.op == OP_REMOVE) begin
              for (i = slot; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
              list_len--;
            end
          end
        end
      end
      OP_SORT: begin
        for (i = 1; i < list_len; i++) begin
          tmp = list_keys[i];
          j = i;
          while (j > 0 && list_keys[j - 1] > tmp) begin
            list_keys[j] = list_keys[j - 1];
            j--;
          end
          list_keys[j] = tmp;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    slte_out_t want;
    slte_out_t got;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      list_len = 0;
      list_replies_q.delete();
      replies_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (list_replies_q.size() == 0) begin
          $error("result word with nothing expected: %h", got);
          bad++;
        end else begin
          want = list_replies_q.pop_front();
          if (got.found !== want.found) begin
            $error("found expected %0d got %0d", want.found, got.found);
            bad++;
          end
          if (got.position !== want.position) begin
            $error("position expected %0d got %0d", want.position, got.position);
            bad++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
            bad++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            bad++;
          end
        end
        replies_seen <= replies_seen + 1;
      end
      if (in_valid && in_ready) begin
        want = apply_list_op(in_data);
        list_replies_q.push_back(want);
        if (want.status == ST_FULL) full_rejects <= full_rejects + 1;
        if (want.status == ST_EMPTY) empty_replies <= empty_replies + 1;
        if (want.found) keys_matched <= keys_matched + 1;
      end
      mismatches  <= mismatches + bad;
      replies_due <= list_replies_q.size();
    end
  end

endmodule

[tb/sorted_list_table_engine_tb.sv]
module sorted_list_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slte_pkg::*;

  localparam int CAPACITY         = 16;
  localparam int LIMIT            = 400000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_PER_PHASE = 410;
  localparam int BURST_LEN        = 24;
  localparam int HOLD_CYCLES      = 150;

  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {GROW, SHRINK, MIXED} burst_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  slte_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  slte_out_t out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycles = 0;
  int words_sent = 0;

  int mismatches;
  int replies_due;
  int replies_seen;
  int full_rejects;
  int empty_replies;
  int keys_matched;

  logic signed [31:0] recent_keys [$];

  always #2 clk = ~clk;

  sorted_list_table_engine #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sorted_list_table_engine_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .replies_due  (replies_due),
    .replies_seen (replies_seen),
    .full_rejects (full_rejects),
    .empty_replies(empty_replies),
    .keys_matched (keys_matched)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [2:0] spare_op();
    case ($urandom_range(2))
      0:       return OP_SPARE0;
      1:       return OP_SPARE1;
      default: return OP_SPARE2;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input burst_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      GROW: begin
        if (r < 45) return OP_APPEND;
        if (r < 85) return OP_INSERT;
        if (r < 94) return OP_SEARCH;
        if (r < 97) return OP_SORT;
        return spare_op();
      end
      SHRINK: begin
        if (r < 50) return OP_REMOVE;
        if (r < 78) return OP_SEARCH;
        if (r < 88) return OP_INSERT;
        if (r < 94) return OP_SORT;
        return spare_op();
      end
      default: begin
        if (r < 20) return OP_APPEND;
        if (r < 40) return OP_INSERT;
        if (r < 62) return OP_REMOVE;
        if (r < 84) return OP_SEARCH;
        if (r < 94) return OP_SORT;
        return spare_op();
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (recent_keys.size() != 0 && r < 45) return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if (r < 75) begin
      case ($urandom_range(7))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 32'sd0;
        3:       return -32'sd1;
        4:       return 32'sd1;
        5:       return 32'sd7;
        6:       return -32'sd7;
        default: return 32'sd100;
      endcase
    end
    return $urandom;
  endfunction

  task automatic offer_word(input logic [2:0] op, input logic signed [31:0] key);
    slte_in_t w;
    w.op  = op;
    w.key = key;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (op == OP_APPEND || op == OP_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    burst_mode_t        mode;
    logic [2:0]         op;
    int                 phase;
    int                 n;
    mode = MIXED;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extremes, absent keys, duplicates, spare codes
    offer_word(OP_SEARCH, 32'sd9);
    offer_word(OP_REMOVE, 32'sd9);
    offer_word(OP_SORT, KEY_MAX);
    offer_word(OP_APPEND, 32'sd0);
    offer_word(OP_APPEND, KEY_MIN);
    offer_word(OP_APPEND, KEY_MAX);
    offer_word(OP_INSERT, -32'sd1);
    offer_word(OP_SEARCH, KEY_MAX);
    offer_word(OP_SEARCH, 32'sd12345);
    offer_word(OP_REMOVE, 32'sd12345);
    offer_word(OP_SORT, 32'sd0);
    offer_word(OP_INSERT, 32'sd5);
    offer_word(OP_INSERT, 32'sd5);
    offer_word(OP_SEARCH, 32'sd5);
    offer_word(OP_REMOVE, 32'sd5);
    offer_word(OP_INSERT, KEY_MIN);
    offer_word(OP_INSERT, KEY_MAX);
    offer_word(OP_SPARE0, -32'sd1);
    offer_word(OP_SPARE1, KEY_MAX);
    offer_word(OP_SPARE2, KEY_MIN);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 50; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 50; end
        default: begin send_idle_pct = 34; stall_pct <= 34; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % BURST_LEN == 0) mode = burst_mode_t'($urandom_range(2));
        if (phase == 0 && n == 150) hold_reqs <= hold_reqs + 1;
        op = pick_op(mode);
        offer_word(op, pick_key());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d list words offered: directed extremes and corner cases, then grow,",
             words_sent);
    $display("shrink and mixed bursts; %0d results checked, %0d full, %0d empty, %0d hits",
             replies_seen, full_rejects, empty_replies, keys_matched);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
